@@ hw/rtl/spwm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spwm_pkg: shared types, constants and sine table for the SPWM generator
// Holds the table geometry, field widths, register indexes and the
// quarter-wave sine table, which is built at elaboration in exact integers.
// ----------------------------------------------------------------------------
package spwm_pkg;

   // Table geometry and scaling
   localparam int QUARTER_SAMPLES = 640;
   localparam int PEAK_COUNT      = 1250;
   localparam int MAX_STEP        = 10;
   localparam int HALF_PERIOD     = 2 * QUARTER_SAMPLES;

   // Field and register widths
   localparam int STEP_W      = 4;
   localparam int GAIN_W      = 15;
   localparam int GAIN_FRAC   = 14;
   localparam int COMPARE_W   = 11;
   localparam int PHASE_W     = $clog2(HALF_PERIOD);
   localparam int POS_W       = $clog2(QUARTER_SAMPLES + 1);
   localparam int ROM_W       = $clog2(PEAK_COUNT + 1);
   localparam int SUM_W       = $clog2(HALF_PERIOD + MAX_STEP);
   localparam int PRODUCT_W   = ROM_W + GAIN_W;
   localparam int SCALED_W    = PRODUCT_W - GAIN_FRAC;
   localparam int SAT_W       = (SCALED_W > COMPARE_W) ? SCALED_W : COMPARE_W;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = GAIN_W;

   // Register reset values
   localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(10);
   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(16384);

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_STEP     = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_AMPLITUDE_GAIN = CSR_INDEX_W'(1);

   // One phase sample handed from the phase accumulator to the scaler
   typedef struct packed {
      logic             half;
      logic [POS_W-1:0] pos;
   } phase_sample_type;

   typedef logic [ROM_W-1:0] sine_rom_type [0:QUARTER_SAMPLES];

   // pi/2 in Q62
   localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

   // Taylor term divisors (2k)(2k+1) for k = 1 .. 16
   localparam logic [63:0] TERM_DIVISOR [1:16] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272,
      64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812, 64'd930, 64'd1056
   };

   // (a * b) >> 62, kept to 64 bits
   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
   endfunction

   // floor(sin(i * pi / (2 * QUARTER_SAMPLES)) * PEAK_COUNT) by series in Q62
   function automatic logic [ROM_W-1:0] sine_entry(input int i);
      logic [63:0] q;
      logic [63:0] r;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] v;
      logic [63:0] iw;
      if (i == 0) begin
         return '0;
      end
      if (i >= QUARTER_SAMPLES) begin
         return ROM_W'(PEAK_COUNT);
      end
      if (3 * i == QUARTER_SAMPLES) begin
         return ROM_W'(PEAK_COUNT / 2);
      end
      iw   = 64'(i);
      q    = HALF_PI_Q62 / 64'(QUARTER_SAMPLES);
      r    = HALF_PI_Q62 % 64'(QUARTER_SAMPLES);
      x    = q * iw + (r * iw) / 64'(QUARTER_SAMPLES);
      x2   = mul_q62(x, x);
      term = x;
      sum  = x;
      for (int k = 1; k <= 16; k++) begin
         term = mul_q62(term, x2) / TERM_DIVISOR[k];
         if ((k % 2) == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      v = mul_q62(sum, 64'(PEAK_COUNT));
      if (v > 64'(PEAK_COUNT)) begin
         v = 64'(PEAK_COUNT);
      end
      return v[ROM_W-1:0];
   endfunction

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      for (int i = 0; i <= QUARTER_SAMPLES; i++) begin
         rom[i] = sine_entry(i);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

endpackage
`default_nettype wire

@@ hw/rtl/spwm_phase_accum.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spwm_phase_accum: phase index and half-cycle state
// Mirrors the phase into a quarter-wave table position and advances the
// phase by the clamped step on every tick that goes to the scaler.
// ----------------------------------------------------------------------------
module spwm_phase_accum (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         advance,
   input  wire logic [spwm_pkg::STEP_W-1:0]  phase_step,
   output spwm_pkg::phase_sample_type        sample
);

   logic [spwm_pkg::PHASE_W-1:0] phase_ff;
   logic [spwm_pkg::PHASE_W-1:0] phase_in;
   logic                         half_ff;
   logic                         half_in;
   logic [spwm_pkg::SUM_W-1:0]   step_clamped;
   logic [spwm_pkg::SUM_W-1:0]   sum_raw;
   logic [spwm_pkg::SUM_W-1:0]   sum_once;
   logic [spwm_pkg::SUM_W-1:0]   sum_wrapped;
   logic [spwm_pkg::PHASE_W-1:0] mirrored;

   // Mirror the phase into the quarter-wave table
   always_comb begin
      if (phase_ff > spwm_pkg::PHASE_W'(spwm_pkg::QUARTER_SAMPLES)) begin
         mirrored = spwm_pkg::PHASE_W'(spwm_pkg::HALF_PERIOD) - phase_ff;
      end else begin
         mirrored = phase_ff;
      end
      sample.half = half_ff;
      sample.pos  = spwm_pkg::POS_W'(mirrored);
   end

   // Clamp the step to 1 .. MAX_STEP
   always_comb begin
      step_clamped = spwm_pkg::SUM_W'(phase_step);
      if (step_clamped == '0) begin
         step_clamped = spwm_pkg::SUM_W'(1);
      end else if (step_clamped > spwm_pkg::SUM_W'(spwm_pkg::MAX_STEP)) begin
         step_clamped = spwm_pkg::SUM_W'(spwm_pkg::MAX_STEP);
      end
   end

   // Advance and wrap at the half-period, toggling the half-cycle
   always_comb begin
      sum_raw  = spwm_pkg::SUM_W'(phase_ff) + step_clamped;
      sum_once = sum_raw;
      half_in  = half_ff;
      if (sum_raw >= spwm_pkg::SUM_W'(spwm_pkg::HALF_PERIOD)) begin
         sum_once = sum_raw - spwm_pkg::SUM_W'(spwm_pkg::HALF_PERIOD);
         half_in  = ~half_ff;
      end
      sum_wrapped = sum_once;
      if (sum_once >= spwm_pkg::SUM_W'(spwm_pkg::HALF_PERIOD)) begin
         sum_wrapped = sum_once - spwm_pkg::SUM_W'(spwm_pkg::HALF_PERIOD);
      end
      phase_in = spwm_pkg::PHASE_W'(sum_wrapped);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         half_ff  <= 1'b0;
      end else if (advance) begin
         phase_ff <= phase_in;
         half_ff  <= half_in;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/spwm_scale_pipe.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spwm_scale_pipe: sine table read, gain multiply and saturation
// Three registered stages with per-stage hold: table word, product, and
// the output word that waits for the consumer.
// ----------------------------------------------------------------------------
module spwm_scale_pipe (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           in_valid,
   output logic                                in_ready,
   input  wire spwm_pkg::phase_sample_type     in_sample,
   input  wire logic [spwm_pkg::GAIN_W-1:0]    amplitude_gain,
   output logic                                out_valid,
   input  wire logic                           out_ready,
   output logic [spwm_pkg::COMPARE_W-1:0]      compare_positive,
   output logic [spwm_pkg::COMPARE_W-1:0]      compare_negative,
   output logic                                negative_half
);

   logic                             s1_valid_ff;
   logic                             s1_half_ff;
   logic [spwm_pkg::ROM_W-1:0]       s1_sine_ff;
   logic                             s2_valid_ff;
   logic                             s2_half_ff;
   logic [spwm_pkg::PRODUCT_W-1:0]   s2_product_ff;
   logic [spwm_pkg::PRODUCT_W-1:0]   s2_product_in;
   logic                             out_valid_ff;
   logic                             out_half_ff;
   logic [spwm_pkg::COMPARE_W-1:0]   out_positive_ff;
   logic [spwm_pkg::COMPARE_W-1:0]   out_negative_ff;
   logic [spwm_pkg::COMPARE_W-1:0]   compare_in;
   logic [spwm_pkg::SCALED_W-1:0]    scaled;
   logic [spwm_pkg::SAT_W-1:0]       saturated;
   logic                             out_take;
   logic                             s2_take;
   logic                             s1_take;

   // Each stage moves when it is empty or the next one moves
   assign out_take = ~out_valid_ff | out_ready;
   assign s2_take  = ~s2_valid_ff | out_take;
   assign s1_take  = ~s1_valid_ff | s2_take;
   assign in_ready = s1_take;

   // Stage 1: registered table read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_take) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && s1_take) begin
         s1_sine_ff <= spwm_pkg::SINE_ROM[in_sample.pos];
         s1_half_ff <= in_sample.half;
      end
   end

   // Stage 2: scale by the gain
   assign s2_product_in = spwm_pkg::PRODUCT_W'(s1_sine_ff) *
                          spwm_pkg::PRODUCT_W'(amplitude_gain);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_take) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s2_take) begin
         s2_product_ff <= s2_product_in;
         s2_half_ff    <= s1_half_ff;
      end
   end

   // Stage 3: drop the fraction, saturate at the peak, steer by half-cycle
   always_comb begin
      scaled = s2_product_ff[spwm_pkg::PRODUCT_W-1:spwm_pkg::GAIN_FRAC];
      if (scaled > spwm_pkg::SCALED_W'(spwm_pkg::PEAK_COUNT)) begin
         saturated = spwm_pkg::SAT_W'(spwm_pkg::PEAK_COUNT);
      end else begin
         saturated = spwm_pkg::SAT_W'(scaled);
      end
      compare_in = saturated[spwm_pkg::COMPARE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_take) begin
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff && out_take) begin
         out_half_ff     <= s2_half_ff;
         out_positive_ff <= s2_half_ff ? '0 : compare_in;
         out_negative_ff <= s2_half_ff ? compare_in : '0;
      end
   end

   assign out_valid        = out_valid_ff;
   assign compare_positive = out_positive_ff;
   assign compare_negative = out_negative_ff;
   assign negative_half    = out_half_ff;

   // Only the active half-cycle's compare may be nonzero
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_half_ff |-> out_positive_ff == '0)
      else $error("positive compare driven in negative half");

   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_half_ff |-> out_negative_ff == '0)
      else $error("negative compare driven in positive half");

   // A compare never exceeds the peak count
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> 32'(out_positive_ff) <= spwm_pkg::PEAK_COUNT &&
                       32'(out_negative_ff) <= spwm_pkg::PEAK_COUNT)
      else $error("compare above peak count");

   // A blocked table word stays in stage 1
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_take |=> s1_valid_ff && $stable(s1_sine_ff))
      else $error("stage 1 word lost under stall");

endmodule
`default_nettype wire

@@ hw/rtl/spwm_quarter_wave_generator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spwm_quarter_wave_generator: sinusoidal PWM compare value generator
// Top level: configuration registers, tick intake and result channel.
// ----------------------------------------------------------------------------
// One tick word is taken every clock cycle while the scaler is not stalled.
// A tick with hold clear gives one result word through the registered sine
// table read, the gain multiply and the saturating output register, which
// holds a result while the consumer stalls. A tick with hold set is always
// taken, gives no result and leaves the phase where it is. The phase step
// and gain registers are written through the csr_ port, which is always
// ready, and should be changed only while no result is pending.
// ----------------------------------------------------------------------------
module spwm_quarter_wave_generator (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_hold,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [spwm_pkg::COMPARE_W-1:0]          rsp_compare_positive,
   output logic [spwm_pkg::COMPARE_W-1:0]          rsp_compare_negative,
   output logic                                    rsp_negative_half,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [spwm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [spwm_pkg::CSR_DATA_W-1:0]    csr_data
);

   logic [spwm_pkg::STEP_W-1:0]  phase_step_ff;
   logic [spwm_pkg::GAIN_W-1:0]  amplitude_gain_ff;
   spwm_pkg::phase_sample_type   sample;
   logic                         pipe_ready;
   logic                         advance;

   // Write configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff     <= spwm_pkg::STEP_RESET;
         amplitude_gain_ff <= spwm_pkg::GAIN_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            spwm_pkg::CSR_PHASE_STEP: begin
               phase_step_ff <= csr_data[spwm_pkg::STEP_W-1:0];
            end
            spwm_pkg::CSR_AMPLITUDE_GAIN: begin
               amplitude_gain_ff <= csr_data[spwm_pkg::GAIN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Drop held ticks at once; pass the rest to the scaler
   assign req_ready = req_hold | pipe_ready;
   assign advance   = req_valid & ~req_hold & pipe_ready;

   spwm_phase_accum u_phase (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .phase_step (phase_step_ff),
      .sample     (sample)
   );

   spwm_scale_pipe u_scale (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (req_valid & ~req_hold),
      .in_ready         (pipe_ready),
      .in_sample        (sample),
      .amplitude_gain   (amplitude_gain_ff),
      .out_valid        (rsp_valid),
      .out_ready        (rsp_ready),
      .compare_positive (rsp_compare_positive),
      .compare_negative (rsp_compare_negative),
      .negative_half    (rsp_negative_half)
   );

endmodule
`default_nettype wire
